// ===== rtl/i2cmbw_pkg.sv =====
`timescale 1ns / 1ps

package i2cmbw_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] DELAY_RESET = 16'd10;
	localparam logic [1:0] PHASE_LAST = 2'd2;
	localparam logic [2:0] BIT_LAST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_BIT,
		ST_ACK,
		ST_STOP
	} seq_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic with_start;
		logic with_stop;
	} job_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic held;
		logic ack_sample;
		logic last_phase;
	} phase_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== rtl/i2cmbw_front.sv =====
`timescale 1ns / 1ps

module i2cmbw_front
	import i2cmbw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // data_byte
	input  logic [1:0] s_axis_tuser,   // with_start, with_stop
	input  fifo_stat_t stat,
	output logic       push,
	output job_t       wr_job
);

	logic valid_s1;
	job_t job_s1;
	logic take;

	assign s_axis_tready = !valid_s1 || !stat.full;
	assign take = s_axis_tvalid && s_axis_tready;
	assign push = valid_s1 && !stat.full;
	assign wr_job = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1.data_byte <= s_axis_tdata;
			job_s1.with_start <= s_axis_tuser[0];
			job_s1.with_stop <= s_axis_tuser[1];
		end
	end

endmodule

// ===== rtl/i2cmbw_fifo.sv =====
`timescale 1ns / 1ps

module i2cmbw_fifo
	import i2cmbw_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       wr_job,
	input  logic       pop,
	output job_t       rd_job,
	output fifo_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== rtl/i2cmbw_back.sv =====
`timescale 1ns / 1ps

module i2cmbw_back
	import i2cmbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] phase_delay,
	input  fifo_stat_t  stat,
	input  job_t        rd_job,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // scl_level, sda_level, held, zero fill
	output logic        m_axis_tuser,   // ack_sample
	output logic        m_axis_tlast
);

	seq_state_t state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic [2:0] bit_q, bit_d;
	job_t cur_q;
	logic scl_q;
	logic [15:0] timer_q;
	logic out_valid_q;
	phase_t out_q;
	phase_t ph;
	logic cur_bit;
	logic advance;

	assign cur_bit = cur_q.data_byte[BIT_LAST - bit_q];
	assign advance = (state_q != ST_IDLE) && (timer_q == '0)
		&& (!out_valid_q || m_axis_tready);

	// phase levels for the current position
	always_comb begin
		ph = '0;
		case (state_q)
			ST_START: begin
				ph.scl_level = (phase_q != PHASE_LAST);
				ph.sda_level = (phase_q == 2'd0);
				ph.held = 1'b1;
			end
			ST_BIT: begin
				ph.scl_level = (phase_q == 2'd0) ? scl_q : (phase_q == 2'd1);
				// sda released after the last data bit
				ph.sda_level = (phase_q == PHASE_LAST && bit_q == BIT_LAST) ? 1'b1 : cur_bit;
				ph.held = 1'b1;
			end
			ST_ACK: begin
				ph.scl_level = (phase_q == 2'd0) ? scl_q : (phase_q == 2'd1);
				ph.sda_level = 1'b1;
				ph.held = 1'b1;
				ph.ack_sample = (phase_q == 2'd1);
				ph.last_phase = (phase_q == PHASE_LAST) && !cur_q.with_stop;
			end
			ST_STOP: begin
				ph.scl_level = (phase_q == 2'd0) ? scl_q : 1'b1;
				ph.sda_level = (phase_q == PHASE_LAST);
				ph.held = (phase_q == 2'd1);
				ph.last_phase = (phase_q == PHASE_LAST);
			end
			default: begin
				ph = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		bit_d = bit_q;
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					state_d = rd_job.with_start ? ST_START : ST_BIT;
					phase_d = '0;
					bit_d = '0;
				end
			end
			ST_START, ST_BIT, ST_ACK, ST_STOP: begin
				if (advance) begin
					if (phase_q != PHASE_LAST) begin
						phase_d = phase_q + 1'b1;
					end else begin
						phase_d = '0;
						case (state_q)
							ST_START: state_d = ST_BIT;
							ST_BIT: begin
								if (bit_q == BIT_LAST) begin
									state_d = ST_ACK;
								end else begin
									bit_d = bit_q + 1'b1;
								end
							end
							ST_ACK: state_d = cur_q.with_stop ? ST_STOP : ST_IDLE;
							default: state_d = ST_IDLE;
						endcase
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			bit_q <= '0;
			scl_q <= 1'b1;
			timer_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			bit_q <= bit_d;
			if (advance) begin
				scl_q <= ph.scl_level;
				out_valid_q <= 1'b1;
				timer_q <= ph.held ? phase_delay : '0;
			end else begin
				if (m_axis_tready) begin
					out_valid_q <= 1'b0;
				end
				if (timer_q != '0) begin
					timer_q <= timer_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd_job;
		end
		if (advance) begin
			out_q <= ph;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'b0, out_q.held, out_q.sda_level, out_q.scl_level};
	assign m_axis_tuser = out_q.ack_sample;
	assign m_axis_tlast = out_q.last_phase;

endmodule

// ===== rtl/i2c_master_byte_writer_top.sv =====
`timescale 1ns / 1ps

// channel    dir  handshake               payload
// s_axis     in   s_axis_tvalid/tready    tdata: data_byte; tuser: with_start, with_stop
// m_axis     out  m_axis_tvalid/tready    tdata: scl, sda, held; tuser: ack_sample; tlast
// cfg        in   cfg_valid/cfg_ready     cfg_data: phase_delay
//
// an item gives 27 phases, 30 with start or stop, 33 with both
// a held phase waits out phase_delay before the next phase, a momentary one does not; fetching the
// next byte delays the bus only after a stop, else it hides under the final held phase
// inputs are taken while a byte is on the bus, until the queue fills
// reset is asynchronous: bus state idle high, phase_delay back to 10
// an output stall freezes the phase sequencer on the pending beat

module i2c_master_byte_writer_top
	import i2cmbw_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	input  logic [1:0]  s_axis_tuser,   // with_start, with_stop
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // scl_level, sda_level, held, zero fill
	output logic        m_axis_tuser,   // ack_sample
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] phase_delay_q;
	fifo_stat_t stat;
	logic push;
	logic pop;
	job_t wr_job;
	job_t rd_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			phase_delay_q <= cfg_data;
		end
	end

	i2cmbw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.stat(stat),
		.push(push),
		.wr_job(wr_job)
	);

	i2cmbw_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_job(wr_job),
		.pop(pop),
		.rd_job(rd_job),
		.stat(stat)
	);

	i2cmbw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.phase_delay(phase_delay_q),
		.stat(stat),
		.rd_job(rd_job),
		.pop(pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

// ===== rtl/i2cmbw_checker.sv =====
`timescale 1ns / 1ps

module i2cmbw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);

	// stalled beat keeps its valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped under stall");

	// stalled beat keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser)
		&& $stable(m_axis_tlast))
		else $error("output payload changed under stall");

	// ack sample point has scl high and sda released
	a_ack_levels: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0] && m_axis_tdata[1] && !m_axis_tlast)
		else $error("ack sample beat with wrong bus levels");

	// momentary phases only occur in a stop; a final momentary one is scl high sda high
	a_stop_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && !m_axis_tdata[2] |-> m_axis_tdata[0] && m_axis_tdata[1])
		else $error("stop does not end with bus released");

endmodule

bind i2c_master_byte_writer_top i2cmbw_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.m_axis_tlast(m_axis_tlast)
);
